FILE: hw/rtl/brim_pkg.sv
// ----------------------------------------------------------------------------
// brim_pkg: shared types and constants of the bilinear remap unit
// Channel widths, item codes, register indexes and the neighbor control word.
// ----------------------------------------------------------------------------
package brim_pkg;

   localparam int SAMPLE_W   = 21;   // signed fixed-point coordinate
   localparam int CHAN_W     = 8;    // one color channel
   localparam int NCHAN      = 3;
   localparam int PIX_W      = NCHAN * CHAN_W;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 7;
   localparam int CFG_W      = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int NBR        = 4;    // 2x2 neighborhood
   localparam int NBANK      = 4;    // banks by (row parity, column parity)

   localparam logic [CHAN_W-1:0] CHAN_MAX  = '1;
   localparam logic [CFG_W-1:0]  DIM_RESET = 8'd128;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 4'd1;

   typedef logic [PIX_W-1:0] pixel_type;

   // Neighbor order: 0 = (x0,y0), 1 = (x0+1,y0), 2 = (x0,y0+1), 3 = (x0+1,y0+1)
   typedef struct packed {
      logic           x0_odd;
      logic           y0_odd;
      logic [NBR-1:0] in_frame;
   } nbr_ctl_type;

endpackage

FILE: hw/rtl/brim_if.sv
// ----------------------------------------------------------------------------
// brim_if: channel interfaces of the bilinear remap unit
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brim_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [6:0]                write_col;
   logic [6:0]                write_row;
   logic [7:0]                pixel_chan0;
   logic [7:0]                pixel_chan1;
   logic [7:0]                pixel_chan2;
   logic signed [20:0]        sample_x;
   logic signed [20:0]        sample_y;

   modport source (output valid, operation, write_col, write_row, pixel_chan0,
                   pixel_chan1, pixel_chan2, sample_x, sample_y, input ready);
   modport sink   (input valid, operation, write_col, write_row, pixel_chan0,
                   pixel_chan1, pixel_chan2, sample_x, sample_y, output ready);
endinterface

interface brim_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_chan0;
   logic [7:0] out_chan1;
   logic [7:0] out_chan2;

   modport source (output valid, out_chan0, out_chan1, out_chan2, input ready);
   modport sink   (input valid, out_chan0, out_chan1, out_chan2, output ready);
endinterface

interface brim_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/brim_bank.sv
// ----------------------------------------------------------------------------
// brim_bank: one parity bank of the source frame store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brim_bank
   import brim_pkg::*;
#(
   parameter int AW = 12
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  pixel_type       wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output pixel_type       rd_data
);

   pixel_type mem [2**AW];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/brim_blend.sv
// ----------------------------------------------------------------------------
// brim_blend: weight, multiply and round pipeline
// Routes bank data to neighbors, forms fraction weights, takes twelve
// products, sums with round half up and clamps. Three stages, each with
// its own valid so bubbles close up under a stalled output.
// ----------------------------------------------------------------------------
module brim_blend
   import brim_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  nbr_ctl_type          in_ctl,
   input  logic [FRAC_BITS-1:0] in_frac_x,
   input  logic [FRAC_BITS-1:0] in_frac_y,
   input  pixel_type            in_bank [NBANK],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [CHAN_W-1:0]    out_chan [NCHAN]
);

   localparam int FW = FRAC_BITS + 1;             // 0..2^F
   localparam int WW = 2 * FRAC_BITS + 1;         // weight up to 2^2F
   localparam int PW = WW + CHAN_W;               // weight x channel
   localparam int SW = 2 * FRAC_BITS + CHAN_W + 1;
   localparam logic [FW-1:0] ONE_C = FW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] RND_C = SW'(1) << (2 * FRAC_BITS - 1);

   logic en2, en3, eno;

   logic                v2_ff, v3_ff, vo_ff;
   logic [WW-1:0]       w2_ff   [NBR];
   logic [CHAN_W-1:0]   p2_ff   [NBR][NCHAN];
   logic [PW-1:0]       prod_ff [NBR][NCHAN];
   logic [CHAN_W-1:0]   chan_ff [NCHAN];

   logic [WW-1:0]       w_in    [NBR];
   logic [CHAN_W-1:0]   p_in    [NBR][NCHAN];
   logic [PW-1:0]       prod_in [NBR][NCHAN];
   logic [CHAN_W-1:0]   chan_in [NCHAN];

   logic [FW-1:0] fx, fy, ox, oy;

   assign eno      = !vo_ff || out_ready;
   assign en3      = !v3_ff || eno;
   assign en2      = !v2_ff || en3;
   assign in_ready = en2;

   // fraction weights
   assign fx = {1'b0, in_frac_x};
   assign fy = {1'b0, in_frac_y};
   assign ox = ONE_C - fx;
   assign oy = ONE_C - fy;

   assign w_in[0] = WW'(ox) * WW'(oy);
   assign w_in[1] = WW'(fx) * WW'(oy);
   assign w_in[2] = WW'(ox) * WW'(fy);
   assign w_in[3] = WW'(fx) * WW'(fy);

   // neighbor n sits in bank {y0 parity ^ dy, x0 parity ^ dx}; outside reads zero
   for (genvar n = 0; n < NBR; n++) begin : g_route
      logic [1:0] sel;
      assign sel = {in_ctl.y0_odd ^ 1'(n / 2), in_ctl.x0_odd ^ 1'(n % 2)};
      for (genvar c = 0; c < NCHAN; c++) begin : g_chan
         assign p_in[n][c] = in_ctl.in_frame[n] ? in_bank[sel][c*CHAN_W +: CHAN_W] : '0;
         assign prod_in[n][c] = PW'(w2_ff[n]) * PW'(p2_ff[n][c]);
      end
   end

   // sum, round half up, clamp
   for (genvar c = 0; c < NCHAN; c++) begin : g_sum
      logic [SW-1:0]     sum;
      logic [CHAN_W:0]   res;
      assign sum = SW'(prod_ff[0][c]) + SW'(prod_ff[1][c]) + SW'(prod_ff[2][c])
                 + SW'(prod_ff[3][c]) + RND_C;
      assign res = sum[SW-1 -: CHAN_W+1];
      assign chan_in[c] = res[CHAN_W] ? CHAN_MAX : res[CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en2) v2_ff <= in_valid;
         if (en3) v3_ff <= v2_ff;
         if (eno) vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         w2_ff <= w_in;
         p2_ff <= p_in;
      end
      if (en3) begin
         prod_ff <= prod_in;
      end
      if (eno) begin
         chan_ff <= chan_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_chan  = chan_ff;

endmodule

FILE: hw/rtl/bilinear_image_remap_unit.sv
// ----------------------------------------------------------------------------
// bilinear_image_remap_unit: bilinear sampler over a banked RGB frame store
// Write transfers fill the store; sample transfers return one blended pixel.
//
//   channel  | dir | transfer carries
//   ---------+-----+-------------------------------------------------------
//   req_bus  | in  | operation, write_col/row, pixel_chan0..2, sample_x/y
//   rsp_bus  | out | out_chan0..2, one per sample transfer
//   csr_bus  | in  | index (0 cols_in_use, 1 rows_in_use), data
//
// One request transfer per cycle while req_bus.ready is high. A sample
// passes four register stages before rsp_bus.valid rises: bank read,
// weights, products, sum. The 2x2 neighborhood is read at once from
// four banks split by row and column parity. A stalled rsp_bus holds the
// output; upstream stages keep accepting until every stage is full. Reset
// (synchronous, active high) clears stage valids and sets both registers
// to 128; the store itself is not cleared.
// ----------------------------------------------------------------------------
module bilinear_image_remap_unit
   import brim_pkg::*;
#(
   parameter int IMG_WIDTH  = 128,
   parameter int IMG_HEIGHT = 128,
   parameter int FRAC_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   brim_req_if.sink    req_bus,
   brim_rsp_if.source  rsp_bus,
   brim_csr_if.sink    csr_bus
);

   // half-index widths of one bank (at least one bit)
   localparam int XHW_R = $clog2((IMG_WIDTH + 1) / 2);
   localparam int YHW_R = $clog2((IMG_HEIGHT + 1) / 2);
   localparam int XHW   = (XHW_R < 1) ? 1 : XHW_R;
   localparam int YHW   = (YHW_R < 1) ? 1 : YHW_R;
   localparam int AW    = XHW + YHW;

   // coordinate width: integer part plus carry of +1, room for limits
   localparam int CW0 = SAMPLE_W - FRAC_BITS + 1;
   localparam int CW1 = (CW0 > $clog2(IMG_WIDTH) + 2)  ? CW0 : $clog2(IMG_WIDTH) + 2;
   localparam int CW2 = (CW1 > $clog2(IMG_HEIGHT) + 2) ? CW1 : $clog2(IMG_HEIGHT) + 2;
   localparam int CW  = (CW2 > CFG_W + 1) ? CW2 : CFG_W + 1;

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] cols_ff, rows_ff;
   logic             csr_xfer;

   assign csr_bus.ready = 1'b1;
   assign csr_xfer      = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_RESET;
         rows_ff <= DIM_RESET;
      end else if (csr_xfer) begin
         if (csr_bus.index == CSR_COLS_IN_USE) cols_ff <= csr_bus.data;
         if (csr_bus.index == CSR_ROWS_IN_USE) rows_ff <= csr_bus.data;
      end
   end

   // ---------------------------------------------------------------- request side
   logic req_xfer, en1, blend_ready;
   logic is_sample;

   assign req_xfer  = req_bus.valid && req_bus.ready;
   assign is_sample = (req_bus.operation == OP_SAMPLE);

   // floor by arithmetic shift; x1/y1 are the right/lower neighbors
   logic signed [SAMPLE_W-1:0] sx_sh, sy_sh;
   logic [CW-1:0] x0, x1, y0, y1;
   logic [1:0]    x_ok, y_ok;
   logic [CW-1:0] cols_lim, rows_lim, w_lim, h_lim;

   assign sx_sh = req_bus.sample_x >>> FRAC_BITS;
   assign sy_sh = req_bus.sample_y >>> FRAC_BITS;
   assign x0    = CW'(sx_sh);
   assign y0    = CW'(sy_sh);
   assign x1    = x0 + CW'(1);
   assign y1    = y0 + CW'(1);

   assign cols_lim = CW'(cols_ff);
   assign rows_lim = CW'(rows_ff);
   assign w_lim    = CW'(IMG_WIDTH);
   assign h_lim    = CW'(IMG_HEIGHT);

   // negative, past the register, or past the store: contributes zero
   assign x_ok[0] = !x0[CW-1] && (x0 < cols_lim) && (x0 < w_lim);
   assign x_ok[1] = !x1[CW-1] && (x1 < cols_lim) && (x1 < w_lim);
   assign y_ok[0] = !y0[CW-1] && (y0 < rows_lim) && (y0 < h_lim);
   assign y_ok[1] = !y1[CW-1] && (y1 < rows_lim) && (y1 < h_lim);

   nbr_ctl_type ctl_in;
   assign ctl_in.x0_odd   = x0[0];
   assign ctl_in.y0_odd   = y0[0];
   assign ctl_in.in_frame = {x_ok[1] && y_ok[1], x_ok[0] && y_ok[1],
                             x_ok[1] && y_ok[0], x_ok[0] && y_ok[0]};

   // write path: bank by parity, address by halved coordinates
   logic [CW-1:0] wcol, wrow;
   logic          wr_ok;
   logic [1:0]    wr_bank;
   logic [AW-1:0] wr_addr;
   pixel_type     wr_data;

   assign wcol    = CW'(req_bus.write_col);
   assign wrow    = CW'(req_bus.write_row);
   assign wr_ok   = req_xfer && !is_sample && (wcol < w_lim) && (wrow < h_lim);
   assign wr_bank = {wrow[0], wcol[0]};
   assign wr_addr = {wrow[YHW:1], wcol[XHW:1]};
   assign wr_data = {req_bus.pixel_chan2, req_bus.pixel_chan1, req_bus.pixel_chan0};

   // ---------------------------------------------------------------- banks
   pixel_type bank_q [NBANK];

   for (genvar b = 0; b < NBANK; b++) begin : g_bank
      logic [CW-1:0] col_sel, row_sel;
      logic [AW-1:0] rd_addr;

      // each parity bank supplies exactly one of the four neighbors
      assign col_sel = (x0[0] == 1'(b % 2)) ? x0 : x1;
      assign row_sel = (y0[0] == 1'(b / 2)) ? y0 : y1;
      assign rd_addr = {row_sel[YHW:1], col_sel[XHW:1]};

      brim_bank #(
         .AW (AW)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_ok && (wr_bank == 2'(b))),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (en1),
         .rd_addr (rd_addr),
         .rd_data (bank_q[b])
      );
   end

   // ---------------------------------------------------------------- read stage
   // A write lands at its transfer edge; a later sample reads the RAM at its
   // own transfer edge, so read-after-write needs no forwarding.
   logic                 v1_ff;
   nbr_ctl_type          ctl1_ff;
   logic [FRAC_BITS-1:0] fx1_ff, fy1_ff;

   assign en1           = !v1_ff || blend_ready;
   assign req_bus.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_xfer && is_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ctl1_ff <= ctl_in;
         fx1_ff  <= req_bus.sample_x[FRAC_BITS-1:0];
         fy1_ff  <= req_bus.sample_y[FRAC_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- blend
   logic [CHAN_W-1:0] blend_chan [NCHAN];

   brim_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_ready  (blend_ready),
      .in_ctl    (ctl1_ff),
      .in_frac_x (fx1_ff),
      .in_frac_y (fy1_ff),
      .in_bank   (bank_q),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_chan  (blend_chan)
   );

   assign rsp_bus.out_chan0 = blend_chan[0];
   assign rsp_bus.out_chan1 = blend_chan[1];
   assign rsp_bus.out_chan2 = blend_chan[2];

endmodule

FILE: hw/rtl/brim_check.sv
// ----------------------------------------------------------------------------
// brim_check: port-level assertions for the bilinear remap unit
// Watches the request and response handshakes; bound to the top level.
// ----------------------------------------------------------------------------
module brim_check
   import brim_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_chan0,
   input logic [CHAN_W-1:0] rsp_chan1,
   input logic [CHAN_W-1:0] rsp_chan2
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // and keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_chan0) && $stable(rsp_chan1)
                                  && $stable(rsp_chan2))
      else $error("rsp payload changed while stalled");

   // pipeline comes out of reset empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // with the output register empty every stage can move, so requests flow
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind bilinear_image_remap_unit brim_check u_brim_check (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_chan0 (rsp_bus.out_chan0),
   .rsp_chan1 (rsp_bus.out_chan1),
   .rsp_chan2 (rsp_bus.out_chan2)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bilinear_image_remap_unit
// Fills the frame store with write transfers, then samples at directed and
// random fixed-point coordinates under several register settings, with the
// sender and the receiver idling at random. Every response transfer is
// compared channel by channel against a bilinear blend of the mirrored store.
// ----------------------------------------------------------------------------
module testbench;
   import brim_pkg::*;

   // Geometry matches the default build of the block.
   localparam int FRAME_COLS   = 128;
   localparam int FRAME_ROWS   = 128;
   localparam int FRAC_BITS    = 8;
   localparam int FRAC_ONE     = 1 << FRAC_BITS;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 7;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 105;    // transfers per phase, fill writes included
   localparam int SETTLE_CYCLES = 10;    // pipeline is four stages deep
   localparam int LIMIT_CYCLES = 400000;
   localparam int CSR_IDX_MAX  = (1 << CSR_IDX_W) - 1;

   typedef struct {
      op_type                    operation;
      logic [COL_W-1:0]          write_col;
      logic [ROW_W-1:0]          write_row;
      logic [CHAN_W-1:0]         pixel_chan0;
      logic [CHAN_W-1:0]         pixel_chan1;
      logic [CHAN_W-1:0]         pixel_chan2;
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
   } remap_request_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the frame store and both registers, computes the
   // blended pixel for each accepted sample and checks responses in order.
   // -------------------------------------------------------------------------
   class remap_scoreboard;
      pixel_type        frame_store [FRAME_COLS*FRAME_ROWS];
      logic [CFG_W-1:0] cols_in_use;
      logic [CFG_W-1:0] rows_in_use;
      pixel_type        expected_pixels [$];
      int               failures;

      function new();
         cols_in_use = DIM_RESET;
         rows_in_use = DIM_RESET;
         failures    = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         if (idx == CSR_COLS_IN_USE) cols_in_use = value;
         else if (idx == CSR_ROWS_IN_USE) rows_in_use = value;
      endfunction

      // registers above the store size act as the store size
      function int col_limit();
         return (int'(cols_in_use) > FRAME_COLS) ? FRAME_COLS : int'(cols_in_use);
      endfunction

      function int row_limit();
         return (int'(rows_in_use) > FRAME_ROWS) ? FRAME_ROWS : int'(rows_in_use);
      endfunction

      // off-frame neighbors read as zero
      function pixel_type neighbor(int x, int y);
         if (x < 0 || y < 0 || x >= col_limit() || y >= row_limit()) return '0;
         return frame_store[y*FRAME_COLS + x];
      endfunction

      function pixel_type blend_pixel(logic signed [SAMPLE_W-1:0] sx,
                                      logic signed [SAMPLE_W-1:0] sy);
         int        xi, yi, x0, y0, fx, fy, sum, r;
         int        weight [NBR];
         pixel_type nbr [NBR];
         pixel_type blended;
         xi = int'(sx);
         yi = int'(sy);
         x0 = xi >>> FRAC_BITS;            // arithmetic shift floors
         y0 = yi >>> FRAC_BITS;
         fx = xi & (FRAC_ONE - 1);
         fy = yi & (FRAC_ONE - 1);
         weight[0] = (FRAC_ONE - fx) * (FRAC_ONE - fy);
         weight[1] = fx * (FRAC_ONE - fy);
         weight[2] = (FRAC_ONE - fx) * fy;
         weight[3] = fx * fy;
         nbr[0] = neighbor(x0,     y0);
         nbr[1] = neighbor(x0 + 1, y0);
         nbr[2] = neighbor(x0,     y0 + 1);
         nbr[3] = neighbor(x0 + 1, y0 + 1);
         for (int c = 0; c < NCHAN; c++) begin
            sum = 0;
            for (int n = 0; n < NBR; n++)
               sum += weight[n] * int'(nbr[n][c*CHAN_W +: CHAN_W]);
            r = (sum + FRAC_ONE*FRAC_ONE/2) >>> (2*FRAC_BITS);  // half up
            if (r > int'(CHAN_MAX)) r = int'(CHAN_MAX);
            blended[c*CHAN_W +: CHAN_W] = r[CHAN_W-1:0];
         end
         return blended;
      endfunction

      function void note_request(remap_request_type item);
         if (item.operation == OP_WRITE)
            frame_store[int'(item.write_row)*FRAME_COLS + int'(item.write_col)] =
               {item.pixel_chan2, item.pixel_chan1, item.pixel_chan0};
         else
            expected_pixels = {expected_pixels,
                               blend_pixel(item.sample_x, item.sample_y)};
      endfunction

      function void check_pixel(pixel_type actual);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: expected no response, actual %h", $time, actual);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         for (int c = 0; c < NCHAN; c++)
            if (actual[c*CHAN_W +: CHAN_W] !== want[c*CHAN_W +: CHAN_W]) begin
               $display("%0t: out_chan%0d expected %0d actual %0d", $time, c,
                        want[c*CHAN_W +: CHAN_W], actual[c*CHAN_W +: CHAN_W]);
               failures++;
            end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block itself
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(CLOCK_PERIOD/2) clock = ~clock;

   brim_req_if req_bus ();
   brim_rsp_if rsp_bus ();
   brim_csr_if csr_bus ();

   bilinear_image_remap_unit #(
      .IMG_WIDTH  (FRAME_COLS),
      .IMG_HEIGHT (FRAME_ROWS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   remap_scoreboard sb = new();

   // Idle odds in percent, changed per phase by the stimulus process.
   int sender_idle_pct   = 24;
   int receiver_idle_pct = 68;

   // Request transfers so far; paces the random phases.
   int sent_count = 0;

   // Which store entries have been written so far. A sample never reaches an
   // in-frame neighbor that is still unwritten: the stimulus fills it first.
   bit pixel_written [FRAME_COLS*FRAME_ROWS];

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // One request transfer: random idle cycles first, then hold valid until
   // ready is seen at a rising edge. Valid stays high on return so that a
   // back-to-back transfer needs no extra assignment in the same step.
   task automatic send_request(input remap_request_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= item.operation;
      req_bus.write_col   <= item.write_col;
      req_bus.write_row   <= item.write_row;
      req_bus.pixel_chan0 <= item.pixel_chan0;
      req_bus.pixel_chan1 <= item.pixel_chan1;
      req_bus.pixel_chan2 <= item.pixel_chan2;
      req_bus.sample_x    <= item.sample_x;
      req_bus.sample_y    <= item.sample_y;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(item);
      sent_count++;
   endtask

   // Write transfer; the unused coordinate fields carry noise.
   task automatic write_pixel(input int col, input int row, input pixel_type pix);
      remap_request_type item;
      item.operation   = OP_WRITE;
      item.write_col   = COL_W'(col);
      item.write_row   = ROW_W'(row);
      item.pixel_chan0 = pix[0*CHAN_W +: CHAN_W];
      item.pixel_chan1 = pix[1*CHAN_W +: CHAN_W];
      item.pixel_chan2 = pix[2*CHAN_W +: CHAN_W];
      item.sample_x    = SAMPLE_W'($urandom);
      item.sample_y    = SAMPLE_W'($urandom);
      pixel_written[row*FRAME_COLS + col] = 1'b1;
      send_request(item);
   endtask

   // Sample transfer at the coordinate cut to the field width. Any in-frame
   // neighbor not yet written gets a random pixel first; the write fields of
   // the sample itself carry noise.
   task automatic sample_at(input int sx, input int sy);
      remap_request_type item;
      int x0, y0, nx, ny;
      item.operation   = OP_SAMPLE;
      item.write_col   = COL_W'($urandom);
      item.write_row   = ROW_W'($urandom);
      item.pixel_chan0 = CHAN_W'($urandom);
      item.pixel_chan1 = CHAN_W'($urandom);
      item.pixel_chan2 = CHAN_W'($urandom);
      item.sample_x    = SAMPLE_W'(sx);
      item.sample_y    = SAMPLE_W'(sy);
      x0 = int'(item.sample_x) >>> FRAC_BITS;
      y0 = int'(item.sample_y) >>> FRAC_BITS;
      for (int dy = 0; dy < 2; dy++)
         for (int dx = 0; dx < 2; dx++) begin
            nx = x0 + dx;
            ny = y0 + dy;
            if (nx >= 0 && ny >= 0 && nx < sb.col_limit() && ny < sb.row_limit()
                && !pixel_written[ny*FRAME_COLS + nx])
               write_pixel(nx, ny, PIX_W'($urandom));
         end
      send_request(item);
   endtask

   // Register write. Valid drops for one cycle after the transfer so that
   // consecutive writes never lower and raise it in the same step.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(idx, value);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop requesting, wait for every outstanding sample, then let the
   // pipeline settle before registers change or the run ends.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random transfer. Most samples land near the top-left of the valid
   // frame where the store is densely written; some cover the full valid
   // frame and a few use fully random coordinates that toggle the high bits.
   task automatic random_transfer();
      int pick, span_x, span_y, xi, yi;
      pick = $urandom_range(99);
      if (pick < 30) begin
         write_pixel($urandom_range(FRAME_COLS-1), $urandom_range(FRAME_ROWS-1),
                     PIX_W'($urandom));
      end else if (pick < 85) begin
         span_x = sb.col_limit();
         span_y = sb.row_limit();
         if (pick < 70) begin
            if (span_x > 12) span_x = 12;
            if (span_y > 12) span_y = 12;
         end
         xi = int'($urandom_range(span_x + 1)) - 1;   // one column either side
         yi = int'($urandom_range(span_y + 1)) - 1;
         sample_at(xi*FRAC_ONE + int'($urandom_range(FRAC_ONE-1)),
                   yi*FRAC_ONE + int'($urandom_range(FRAC_ONE-1)));
      end else begin
         sample_at(int'($urandom), int'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: check on each transfer, then pick ready for next cycle.
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_pixel({rsp_bus.out_chan2, rsp_bus.out_chan1, rsp_bus.out_chan0});
         rsp_bus.ready <= !reset && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog: cycle counter with a generous bound.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** bilinear_image_remap_unit: FAILED **");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int cols, rows, phase_end;
      // every input known from time zero
      req_bus.valid       <= 1'b0;
      req_bus.operation   <= OP_WRITE;
      req_bus.write_col   <= '0;
      req_bus.write_row   <= '0;
      req_bus.pixel_chan0 <= '0;
      req_bus.pixel_chan1 <= '0;
      req_bus.pixel_chan2 <= '0;
      req_bus.sample_x    <= '0;
      req_bus.sample_y    <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_COLS_IN_USE;
      csr_bus.data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, registers at their reset value of 128.
      // Corner 2x2 blocks with channel extremes.
      write_pixel(0, 0, 24'hFFFFFF);
      write_pixel(1, 0, 24'h000000);
      write_pixel(0, 1, 24'h00FF00);
      write_pixel(1, 1, 24'hFF00FF);
      write_pixel(FRAME_COLS-1, FRAME_ROWS-1, 24'hFFFFFF);
      write_pixel(FRAME_COLS-2, FRAME_ROWS-1, 24'h000000);
      // integer position, no blending
      sample_at(0, 0);
      // halfway between 255 and 0: exact half rounds up
      sample_at(FRAC_ONE/2, 0);
      sample_at(FRAC_ONE/2, FRAC_ONE/2);
      // largest fraction on both axes
      sample_at(FRAC_ONE-1, FRAC_ONE-1);
      // just below the origin: three neighbors off the frame
      sample_at(-1, -1);
      sample_at(-FRAC_ONE/2, FRAC_ONE/4);
      // bottom-right edge: right and lower neighbors off the frame, then all inside
      sample_at((FRAME_COLS-1)*FRAC_ONE + FRAC_ONE/2, (FRAME_ROWS-1)*FRAC_ONE + FRAC_ONE/2);
      sample_at((FRAME_COLS-2)*FRAC_ONE + 3*FRAC_ONE/4, (FRAME_ROWS-2)*FRAC_ONE + 1);
      // first column past the frame
      sample_at(FRAME_COLS*FRAC_ONE, 0);
      // coordinate extremes
      sample_at(1048575, 1048575);
      sample_at(-1048576, -1048576);
      sample_at(1048575, 0);
      sample_at(0, -1048576);

      // Random phases, each with its own register setting. Idle odds:
      // sender lighter than receiver, then reversed, then no idling.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin cols = 128; rows = 128; end
            1: begin cols = 1;   rows = 1;   end   // single pixel frame
            2: begin cols = 0;   rows = 77;  end   // zero columns: all black
            3: begin cols = 255; rows = 129; end   // beyond store size
            default: begin
               cols = $urandom_range(1, FRAME_COLS);
               rows = $urandom_range(1, FRAME_ROWS);
            end
         endcase
         case (phase / 2)
            0: begin sender_idle_pct = 24; receiver_idle_pct = 68; end
            1: begin sender_idle_pct = 68; receiver_idle_pct = 24; end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         endcase
         csr_write(CSR_COLS_IN_USE, CFG_W'(cols));
         csr_write(CSR_ROWS_IN_USE, CFG_W'(rows));
         // index past the register map must be ignored
         csr_write(CSR_IDX_W'($urandom_range(int'(CSR_ROWS_IN_USE) + 1, CSR_IDX_MAX)),
                   CFG_W'($urandom));
         phase_end = sent_count + PHASE_ITEMS;
         while (sent_count < phase_end)
            random_transfer();
      end

      wait_idle();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("** bilinear_image_remap_unit: PASSED **");
      end else begin
         $display("** bilinear_image_remap_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/brim_pkg.sv
hw/rtl/brim_if.sv
hw/rtl/brim_bank.sv
hw/rtl/brim_blend.sv
hw/rtl/bilinear_image_remap_unit.sv
hw/rtl/brim_check.sv
sim/testbench.sv
